// File: src/fhcb_pkg.sv
// Shared constants, types and helpers for the frame header checksum builder.
`default_nettype none
package fhcb_pkg;

	// Field widths of one request on each side.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned DSUM_W  = 24;
	localparam int unsigned FSUM_W  = 25;

	// Descriptor bus: seq, len, header sum, frame sum, padded to whole bytes.
	localparam int unsigned DESC_BITS = 3 * WORD_W + FSUM_W;
	localparam int unsigned TDATA_W   = ((DESC_BITS + 7) / 8) * 8;

	// Bit positions of the descriptor fields inside the output tdata.
	localparam int unsigned SEQ_LSB  = 0;
	localparam int unsigned LEN_LSB  = SEQ_LSB + WORD_W;
	localparam int unsigned HDR_LSB  = LEN_LSB + WORD_W;
	localparam int unsigned FSUM_LSB = HDR_LSB + WORD_W;

	// Framing sync and trailer words and the reset value of the length limit.
	localparam logic [WORD_W-1:0] SYNC_WORD     = 16'hAA55;
	localparam logic [WORD_W-1:0] TRAILER_WORD  = 16'h55AA;
	localparam logic [WORD_W-1:0] MAX_LEN_RESET = 16'd1000;
	localparam logic [WORD_W-1:0] LEN_SAT       = 16'hFFFF;

	// Input stage register contents.
	typedef struct packed {
		logic              last;
		logic [BYTE_W-1:0] data;
	} in_stage_t;

	// Sum of the two bytes of a 16-bit word.
	function automatic logic [BYTE_W:0] byte_pair_sum(input logic [WORD_W-1:0] w);
		byte_pair_sum = {1'b0, w[7:0]} + {1'b0, w[15:8]};
	endfunction

endpackage
`default_nettype wire

// File: src/frame_header_checksum_builder.sv
// Top level: payload byte accumulator and frame descriptor builder.
// A byte request is first registered in the input stage and processed from there; a
// descriptor caused by a last byte is then registered in the output register.
// Throughput: one byte per cycle; a last byte waits in the input stage only while the
// output register still holds an untaken descriptor.
// Reset (arst_n low, asynchronous) clears the sequence, count, sum and valid flags,
// and sets the length limit to 1000.
`default_nettype none
module frame_header_checksum_builder (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Length limit register.
	input  wire logic                        cfg_we,
	input  wire logic [15:0]                 cfg_wdata,
	// Byte stream in.
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // payload_byte[7:0]
	input  wire logic                        s_axis_tlast,  // last_byte
	// Descriptor stream out.
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [fhcb_pkg::TDATA_W-1:0]     m_axis_tdata,  // seq_number[15:0],
	                                                        // payload_len[31:16],
	                                                        // header_sum[47:32],
	                                                        // frame_sum[72:48], zeros
	output logic                             m_axis_tuser   // too_long
);

	localparam int unsigned WW = fhcb_pkg::WORD_W;
	localparam int unsigned DW = fhcb_pkg::DSUM_W;
	localparam int unsigned FW = fhcb_pkg::FSUM_W;
	localparam int unsigned PW = fhcb_pkg::BYTE_W + 1;

	// Framing byte contribution: sync word plus trailer word.
	localparam logic [FW-1:0] MAGIC_BYTES =
		FW'(fhcb_pkg::byte_pair_sum(fhcb_pkg::SYNC_WORD)) +
		FW'(fhcb_pkg::byte_pair_sum(fhcb_pkg::TRAILER_WORD));

	logic                    v_s1;
	fhcb_pkg::in_stage_t     in_s1;
	logic [WW-1:0]           max_len_q;
	logic [WW-1:0]           next_seq_q;
	logic [WW-1:0]           count_q;
	logic [DW-1:0]           data_sum_q;
	logic                    out_valid_q;
	logic [fhcb_pkg::TDATA_W-1:0] out_data_q;
	logic                    out_user_q;

	logic                    in_accept;
	logic                    out_free;
	logic                    advance;
	logic [WW-1:0]           len_inc;
	logic [DW-1:0]           sum_nxt;
	logic                    too_long;
	logic [WW-1:0]           hdr_sum;
	logic [FW-1:0]           frame_sum;
	logic [PW-1:0]           seq_bytes;
	logic [PW-1:0]           len_bytes;
	logic [PW-1:0]           hdr_bytes;

	// Handshake: the input stage moves on unless a last byte meets a full output.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = v_s1 && (!in_s1.last || out_free);
	assign s_axis_tready = !v_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= fhcb_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			in_s1.data <= s_axis_tdata;
			in_s1.last <= s_axis_tlast;
		end
	end

	// Running count and sum including the staged byte, and the header checksum.
	always_comb begin
		len_inc   = (count_q == fhcb_pkg::LEN_SAT) ? count_q : count_q + WW'(1);
		sum_nxt   = data_sum_q + DW'(in_s1.data);
		too_long  = len_inc > max_len_q;
		hdr_sum   = ~(fhcb_pkg::SYNC_WORD + next_seq_q + len_inc);
		seq_bytes = fhcb_pkg::byte_pair_sum(next_seq_q);
		len_bytes = fhcb_pkg::byte_pair_sum(len_inc);
		hdr_bytes = fhcb_pkg::byte_pair_sum(hdr_sum);
		frame_sum = FW'(sum_nxt) + FW'(seq_bytes) + FW'(len_bytes) + FW'(hdr_bytes)
			+ MAGIC_BYTES;
	end

	// Frame state: accumulate on plain bytes; on a last byte, clear and advance the sequence unless too long.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= '0;
			count_q    <= '0;
			data_sum_q <= '0;
		end else if (advance) begin
			if (in_s1.last) begin
				count_q    <= '0;
				data_sum_q <= '0;
				if (!too_long) begin
					next_seq_q <= next_seq_q + WW'(1);
				end
			end else begin
				count_q    <= len_inc;
				data_sum_q <= sum_nxt;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && in_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output descriptor; a rejected frame carries all-zero fields.
	always_ff @(posedge clk) begin
		if (advance && in_s1.last) begin
			out_user_q <= too_long;
			if (too_long) begin
				out_data_q <= '0;
			end else begin
				out_data_q <= fhcb_pkg::TDATA_W'({frame_sum, hdr_sum, len_inc, next_seq_q});
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

// File: src/fhcb_checker.sv
// Port-level assertions for the frame header checksum builder, with its bind.
`default_nettype none
module fhcb_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        m_axis_tvalid,
	input wire logic                        m_axis_tready,
	input wire logic [fhcb_pkg::TDATA_W-1:0] m_axis_tdata,
	input wire logic                        m_axis_tuser
);

	localparam int unsigned WW = fhcb_pkg::WORD_W;

	logic [WW-1:0] seq_f;
	logic [WW-1:0] len_f;
	logic [WW-1:0] hdr_f;
	logic [WW-1:0] hdr_exp;

	assign seq_f   = m_axis_tdata[fhcb_pkg::SEQ_LSB +: WW];
	assign len_f   = m_axis_tdata[fhcb_pkg::LEN_LSB +: WW];
	assign hdr_f   = m_axis_tdata[fhcb_pkg::HDR_LSB +: WW];
	assign hdr_exp = ~(fhcb_pkg::SYNC_WORD + seq_f + len_f);

	// A stalled descriptor stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("descriptor withdrawn while stalled");

	// A stalled descriptor keeps its contents.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("descriptor changed while stalled");

	// A rejected frame carries no descriptor contents.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("rejected frame with nonzero fields");

	// An accepted frame has a consistent header checksum and a nonzero length.
	a_hdr_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> hdr_f == hdr_exp && len_f != '0)
		else $error("header checksum mismatch");

endmodule

bind frame_header_checksum_builder fhcb_checker u_fhcb_checker (.*);
`default_nettype wire

// File: tb/tb_frame_header_checksum_builder.sv
// Testbench for the frame header checksum builder: a directed table, then random frames.
`default_nettype none
module tb_frame_header_checksum_builder;

	// One frame descriptor as the output stream carries it.
	typedef struct packed {
		logic [fhcb_pkg::WORD_W-1:0] seq;
		logic [fhcb_pkg::WORD_W-1:0] len;
		logic [fhcb_pkg::WORD_W-1:0] hdr;
		logic [fhcb_pkg::FSUM_W-1:0] fsum;
		logic                        too_long;
	} desc_t;

	// A directed row either sends one byte request or sets a new length limit.
	typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [fhcb_pkg::WORD_W-1:0] value;
		logic                        last;
		logic                        typed;
		desc_t                       fixed_desc;
	} dir_row_t;

	localparam desc_t NO_DESC  = '0;
	localparam desc_t REJECTED = '{seq: '0, len: '0, hdr: '0, fsum: '0, too_long: 1'b1};

	// The first frame after reset holds one zero byte and can be worked out by hand.
	localparam desc_t FIRST_DESC = '{seq: 16'h0000, len: 16'h0001, hdr: 16'h55A9,
		fsum: 25'd765, too_long: 1'b0};

	localparam int DIR_COUNT = 19;
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{ROW_BYTE,  16'h0000, 1'b1, 1'b1, FIRST_DESC},
		'{ROW_BYTE,  16'h00FF, 1'b1, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h0080, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h007F, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h0001, 1'b1, 1'b0, NO_DESC},
		'{ROW_LIMIT, 16'h0001, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h005A, 1'b1, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h0011, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h0022, 1'b1, 1'b1, REJECTED},
		'{ROW_LIMIT, 16'h0000, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h0033, 1'b1, 1'b1, REJECTED},
		'{ROW_LIMIT, 16'h0002, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h00FF, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h00FF, 1'b1, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h0000, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h0000, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h0000, 1'b1, 1'b1, REJECTED},
		'{ROW_LIMIT, 16'hFFFF, 1'b0, 1'b0, NO_DESC},
		'{ROW_BYTE,  16'h00A5, 1'b1, 1'b0, NO_DESC}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [15:0]                   cfg_wdata;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata;   // payload_byte[7:0]
	logic                          s_axis_tlast;   // last_byte
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [fhcb_pkg::TDATA_W-1:0]  m_axis_tdata;   // seq_number, payload_len, header_sum,
	                                               // frame_sum, zeros
	logic                          m_axis_tuser;   // too_long

	// Predictor state and the descriptors still owed by the block.
	logic [fhcb_pkg::WORD_W-1:0] seq_ctr;
	logic [fhcb_pkg::WORD_W-1:0] len_acc;
	logic [fhcb_pkg::DSUM_W-1:0] sum_acc;
	logic [fhcb_pkg::WORD_W-1:0] len_limit;
	desc_t             pending_desc [$];
	desc_t             oldest_desc;
	int                error_count;
	int                burst_left;
	int                stall_window;
	int                stall_pct;
	bit                hold_req;
	bit                hold_done;

	frame_header_checksum_builder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sum of the low and high byte of a header word.
	function automatic logic [fhcb_pkg::FSUM_W-1:0] word_byte_sum(
			input logic [fhcb_pkg::WORD_W-1:0] w);
		return fhcb_pkg::FSUM_W'(w[7:0]) + fhcb_pkg::FSUM_W'(w[15:8]);
	endfunction

	// Advances the frame state by one byte; returns 1 when a descriptor is due.
	function automatic bit frame_step(input logic [7:0] b, input logic l, output desc_t d);
		logic [fhcb_pkg::WORD_W-1:0] len;
		logic [fhcb_pkg::DSUM_W-1:0] sum;
		logic [fhcb_pkg::WORD_W-1:0] hdr;
		len = (len_acc == fhcb_pkg::LEN_SAT) ? fhcb_pkg::LEN_SAT : len_acc + 16'd1;
		sum = sum_acc + fhcb_pkg::DSUM_W'(b);
		d = NO_DESC;
		if (!l) begin
			len_acc = len;
			sum_acc = sum;
			return 1'b0;
		end
		len_acc = '0;
		sum_acc = '0;
		// An overlong frame is flagged and does not take a sequence number.
		if (len > len_limit) begin
			d = REJECTED;
			return 1'b1;
		end
		hdr = ~(fhcb_pkg::SYNC_WORD + seq_ctr + len);
		d.seq = seq_ctr;
		d.len = len;
		d.hdr = hdr;
		d.fsum = word_byte_sum(fhcb_pkg::SYNC_WORD) + word_byte_sum(seq_ctr)
			+ word_byte_sum(len) + word_byte_sum(hdr) + fhcb_pkg::FSUM_W'(sum)
			+ word_byte_sum(fhcb_pkg::TRAILER_WORD);
		seq_ctr = seq_ctr + 16'd1;
		return 1'b1;
	endfunction

	// Offers one byte request in bursts with gaps, and books its descriptor on acceptance.
	task automatic push_byte(input logic [7:0] b, input logic l, input logic typed,
			input desc_t fixed_desc);
		desc_t d;
		int    gap;
		@(negedge clk);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= l;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (frame_step(b, l, d))
			pending_desc.push_back(typed ? fixed_desc : d);
	endtask

	// Sends one frame of random bytes with the mark on its final byte.
	task automatic send_frame(input int flen);
		for (int k = 0; k < flen; k++)
			push_byte(8'($urandom_range(0, 255)), k == flen - 1, 1'b0, NO_DESC);
	endtask

	// Writes the length limit once the block has drained.
	task automatic set_limit(input logic [fhcb_pkg::WORD_W-1:0] v);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_desc.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		len_limit = v;
	endtask

	// Compares one descriptor field and reports a mismatch.
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Stimulus: reset, directed table, then random phases under several limits.
	initial begin
		int sent;
		int flen;
		int pick;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		seq_ctr       = '0;
		len_acc       = '0;
		sum_acc       = '0;
		len_limit     = fhcb_pkg::MAX_LEN_RESET;
		error_count   = 0;
		burst_left    = 0;
		hold_req      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_COUNT; i++) begin
			if (DIR_ROWS[i].kind == ROW_LIMIT)
				set_limit(DIR_ROWS[i].value);
			else
				push_byte(DIR_ROWS[i].value[7:0], DIR_ROWS[i].last, DIR_ROWS[i].typed,
					DIR_ROWS[i].fixed_desc);
		end

		// Random frames, mostly short, under several limits.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_limit(16'd5);
				1: set_limit(fhcb_pkg::MAX_LEN_RESET);
				2: set_limit(16'd0);
				3: set_limit(16'($urandom_range(1, 65535)));
				default: set_limit(16'd24);
			endcase
			if (p == 0)
				hold_req = 1'b1;
			sent = 0;
			while (sent < 330) begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					flen = 1;
				else if (pick < 8)
					flen = $urandom_range(2, 8);
				else
					flen = $urandom_range(9, 40);
				send_frame(flen);
				sent += flen;
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_desc.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Receiver: stall rates that change every window, with one long hold-off.
	initial begin
		m_axis_tready = 1'b0;
		hold_done     = 1'b0;
		stall_window  = 0;
		stall_pct     = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_done = 1'b1;
			end
			if (stall_window == 0) begin
				stall_window = $urandom_range(32, 160);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			stall_window--;
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Checks each accepted descriptor request against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_desc.size() == 0) begin
				$display("%0t: descriptor mismatch: expected none, actual 0x%0h", $time,
					m_axis_tdata);
				error_count++;
			end else begin
				oldest_desc = pending_desc.pop_front();
				check_field("seq_number", 32'(oldest_desc.seq),
					32'(m_axis_tdata[fhcb_pkg::SEQ_LSB +: fhcb_pkg::WORD_W]));
				check_field("payload_len", 32'(oldest_desc.len),
					32'(m_axis_tdata[fhcb_pkg::LEN_LSB +: fhcb_pkg::WORD_W]));
				check_field("header_sum", 32'(oldest_desc.hdr),
					32'(m_axis_tdata[fhcb_pkg::HDR_LSB +: fhcb_pkg::WORD_W]));
				check_field("frame_sum", 32'(oldest_desc.fsum),
					32'(m_axis_tdata[fhcb_pkg::FSUM_LSB +: fhcb_pkg::FSUM_W]));
				check_field("too_long", 32'(oldest_desc.too_long), 32'(m_axis_tuser));
			end
		end
	end

	// Watchdog for a stuck run.
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
